/* hw/rtl/slsm_pkg.sv */
package slsm_pkg;

	localparam int LINE_MAX = 6;
	localparam int IDX_W    = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 5;
	localparam int CNT_W    = 8;
	localparam int SYNC_W   = 3;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TX_WORD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TX_HEADER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_TICKS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 2'd3;

	localparam logic [WORD_W-1:0] TX_WORD_RST     = 32'h7AE5_6F55;
	localparam logic [SYNC_W-1:0] SYNC_TICKS_RST  = 3'd6;
	localparam logic [CNT_W-1:0]  ERROR_LIMIT_RST = 8'd5;
	localparam logic [CNT_W-1:0]  CNT_SAT         = 8'hFF;

	localparam logic KIND_DRIVE  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// One tick's worth of output, as handed from the link logic to the output queue.
	typedef struct packed {
		logic                kind;
		logic                clk_lvl;
		logic                dat_lvl;
		logic                resync;
		logic [CNT_W-1:0]    err;
		logic [LINE_MAX-1:0] bad;
		logic [LINE_MAX-1:0] hdr;
	} desc_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             over;
	} merge_t;

endpackage

/* hw/rtl/slsm_lane.sv */
module slsm_lane (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [slsm_pkg::POS_W-1:0] pos,
	input  logic                      bit_in,
	output slsm_pkg::word_t           word,
	output logic                      parity
);
	import slsm_pkg::*;

	word_t word_q;
	logic  parity_q;

	// The first payload bit starts a fresh word and a fresh parity.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (pos == '0) begin
				word_q   <= WORD_W'(bit_in);
				parity_q <= bit_in;
			end else begin
				word_q[pos] <= bit_in;
				parity_q    <= parity_q ^ bit_in;
			end
		end
	end

	assign word   = word_q;
	assign parity = parity_q;

endmodule

/* hw/rtl/slsm_merge.sv */
module slsm_merge #(
	parameter int LINE_COUNT = 6
) (
	input  logic [LINE_COUNT-1:0]      bad,
	input  logic [slsm_pkg::CNT_W-1:0] count_q,
	input  logic [slsm_pkg::CNT_W-1:0] limit,
	output slsm_pkg::merge_t           result
);
	import slsm_pkg::*;

	logic [IDX_W-1:0] ones;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] sat;

	always_comb begin
		ones = '0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			ones = ones + IDX_W'(bad[i]);
		end
		sum = {1'b0, count_q} + (CNT_W+1)'(ones);
		if (bad == '0) begin
			sat = '0;
		end else if (sum[CNT_W]) begin
			sat = CNT_SAT;
		end else begin
			sat = sum[CNT_W-1:0];
		end
		result.over  = (sat > limit);
		result.count = result.over ? '0 : sat;
	end

endmodule

/* hw/rtl/slsm_outq.sv */
module slsm_outq #(
	parameter int LINE_COUNT = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  slsm_pkg::desc_t              desc,
	input  slsm_pkg::word_t              words [LINE_COUNT],
	output logic                         ready,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [slsm_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast
);
	import slsm_pkg::*;

	desc_t            head_q, tail_q;
	logic             head_v_q, tail_v_q;
	logic [IDX_W-1:0] lane_q;
	word_t            words_ext [2**IDX_W];
	logic             last_o, pop, step;
	word_t            o_word;
	logic             o_hdr, o_bad;
	logic [IDX_W-1:0] o_idx;

	always_comb begin
		for (int i = 0; i < 2**IDX_W; i++) begin
			words_ext[i] = '0;
		end
		for (int i = 0; i < LINE_COUNT; i++) begin
			words_ext[i] = words[i];
		end
	end

	assign last_o = (head_q.kind == KIND_DRIVE) || (lane_q == IDX_W'(LINE_COUNT - 1));
	assign pop    = head_v_q && m_tready && last_o;
	assign step   = head_v_q && m_tready && !last_o;
	assign ready  = !tail_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
			lane_q   <= '0;
		end else begin
			if (pop) begin
				lane_q <= '0;
				if (tail_v_q) begin
					tail_v_q <= 1'b0;
				end else if (!push) begin
					head_v_q <= 1'b0;
				end
			end else begin
				if (step) begin
					lane_q <= lane_q + 1'b1;
				end
				if (push) begin
					if (!head_v_q) begin
						head_v_q <= 1'b1;
					end else begin
						tail_v_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_v_q) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= desc;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= desc;
			end else begin
				tail_q <= desc;
			end
		end
	end

	always_comb begin
		if (head_q.kind == KIND_REPORT) begin
			o_idx  = lane_q;
			o_word = words_ext[lane_q];
			o_hdr  = head_q.hdr[lane_q];
			o_bad  = head_q.bad[lane_q];
		end else begin
			o_idx  = '0;
			o_word = '0;
			o_hdr  = 1'b0;
			o_bad  = 1'b0;
		end
	end

	assign m_tvalid = head_v_q;
	assign m_tuser  = head_q.kind;
	assign m_tlast  = last_o;
	assign m_tdata  = {head_q.err, head_q.resync, o_bad, o_hdr, o_word, o_idx,
		head_q.dat_lvl, head_q.clk_lvl};

endmodule

/* hw/rtl/six_lane_serial_link_master.sv */
// Master of a six-line serial link. Every request on the slave side is one link
// tick: s_tdata carries the six line levels sampled during the tick just driven.
// Each tick the block advances the frame (resync echo, align, two low ticks,
// header, payload, parity) and answers with the clock and data levels to drive
// on the next tick. A tick that samples the parity bit answers with one report
// request per line (line index, word, header, parity-bad flag, error count);
// any other tick answers with a single drive request. tlast marks the final
// request caused by a tick and tuser says which kind it is.
// The answer to a tick is registered in the output queue, whose head entry
// drives the master side. Throughput: one tick per cycle while the output is
// not stalled; a report tick holds the output while the head entry steps
// through the lanes one request at a time.
// A two-entry output queue lets one further tick be taken while a result waits.
// When the receiver stalls, the queue fills and s_tready drops; no request is
// lost. Reset puts the link into the resync echo phase with the clock high,
// clears the error count and loads the register reset values.
// Registers are written through cfg_we / cfg_index / cfg_data while the link
// is idle; the user must keep to this, as the block does not enforce it. A
// write takes effect from the next driven bit.
module six_lane_serial_link_master #(
	parameter int LINE_COUNT = 6,
	parameter int FRAME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] lines_in, [7:6] zero
	input  logic [slsm_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] clock_out, [1] data_out, [4:2] line_index, [36:5] line_word,
	// [37] line_header, [38] line_bad, [39] resyncing, [47:40] error_count
	output logic [slsm_pkg::OUT_W-1:0]        m_tdata,
	// [0] kind
	output logic                              m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [slsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import slsm_pkg::*;

	typedef enum logic [6:0] {
		PH_ECHO   = 7'b0000001,
		PH_ALIGN  = 7'b0000010,
		PH_LOW1   = 7'b0000100,
		PH_LOW2   = 7'b0001000,
		PH_HEADER = 7'b0010000,
		PH_DATA   = 7'b0100000,
		PH_PARITY = 7'b1000000
	} phase_t;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS - 1);

	// Configuration registers.
	word_t             tx_word_q;
	logic              tx_header_q;
	logic [SYNC_W-1:0] sync_ticks_q;
	logic [CNT_W-1:0]  error_limit_q;

	// Link state.
	phase_t             ph_q, ph_n;
	logic               clk_lvl_q;
	logic [SYNC_W-1:0]  run_q, run_n, run_inc;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [LINE_COUNT-1:0] hdr_q, hdr_n;
	logic               txpar_q, txpar_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;

	logic [LINE_COUNT-1:0] lines, lane_par, bad;
	logic               accept, new_clk, match, report, lane_wr, dat;
	word_t              lane_words [LINE_COUNT];
	merge_t             mrg;
	desc_t              desc;
	logic               q_ready;

	assign lines   = s_tdata[LINE_COUNT-1:0];
	assign s_tready = q_ready;
	assign accept  = s_tvalid && q_ready;
	assign new_clk = !clk_lvl_q;
	assign match   = (lines == (clk_lvl_q ? {LINE_COUNT{1'b1}} : '0));
	assign run_inc = (run_q == {SYNC_W{1'b1}}) ? run_q : run_q + 1'b1;

	// One receive lane per input line: stores its payload bit at the current position and keeps its parity.
	for (genvar g = 0; g < LINE_COUNT; g++) begin : g_lane
		slsm_lane u_lane (
			.clk    (clk),
			.wr_en  (accept && lane_wr),
			.pos    (pos_q),
			.bit_in (lines[g]),
			.word   (lane_words[g]),
			.parity (lane_par[g])
		);
	end

	assign bad = lines ^ lane_par;

	// Merges the per-lane parity verdicts into the running error count, clearing it on a clean frame or past the limit.
	slsm_merge #(
		.LINE_COUNT (LINE_COUNT)
	) u_merge (
		.bad     (bad),
		.count_q (cnt_q),
		.limit   (error_limit_q),
		.result  (mrg)
	);

	always_comb begin
		ph_n    = ph_q;
		run_n   = run_q;
		pos_n   = pos_q;
		hdr_n   = hdr_q;
		cnt_n   = cnt_q;
		report  = 1'b0;
		lane_wr = 1'b0;
		case (ph_q)
			PH_ECHO: begin
				if (match) begin
					if (run_inc >= sync_ticks_q) begin
						run_n = '0;
						ph_n  = new_clk ? PH_ALIGN : PH_LOW1;
					end else begin
						run_n = run_inc;
					end
				end else begin
					run_n = '0;
				end
			end
			PH_ALIGN: begin
				ph_n = PH_LOW1;
			end
			PH_LOW1: begin
				ph_n = (lines != '0) ? PH_ECHO : PH_LOW2;
			end
			PH_LOW2: begin
				ph_n = (lines != '0) ? PH_ECHO : PH_HEADER;
			end
			PH_HEADER: begin
				hdr_n = lines;
				pos_n = '0;
				ph_n  = PH_DATA;
			end
			PH_DATA: begin
				lane_wr = 1'b1;
				if (pos_q >= POS_LAST) begin
					pos_n = '0;
					ph_n  = PH_PARITY;
				end else begin
					pos_n = pos_q + 1'b1;
				end
			end
			PH_PARITY: begin
				report = 1'b1;
				cnt_n  = mrg.count;
				if (mrg.over) begin
					run_n = '0;
					ph_n  = PH_ECHO;
				end else begin
					ph_n = PH_HEADER;
				end
			end
			default: begin
				ph_n  = PH_ECHO;
				run_n = '0;
			end
		endcase

		// Data level for the next tick follows the phase just entered.
		txpar_n = txpar_q;
		case (ph_n)
			PH_LOW1, PH_LOW2: begin
				dat = 1'b0;
			end
			PH_HEADER: begin
				dat = tx_header_q;
			end
			PH_DATA: begin
				dat     = tx_word_q[pos_n];
				txpar_n = txpar_q ^ dat;
			end
			PH_PARITY: begin
				dat     = txpar_q;
				txpar_n = 1'b0;
			end
			default: begin
				dat = 1'b1;
			end
		endcase

		desc.kind    = report ? KIND_REPORT : KIND_DRIVE;
		desc.clk_lvl = new_clk;
		desc.dat_lvl = dat;
		desc.resync  = (ph_n inside {PH_ECHO, PH_ALIGN, PH_LOW1, PH_LOW2});
		desc.err     = cnt_n;
		desc.bad     = LINE_MAX'(bad);
		desc.hdr     = LINE_MAX'(hdr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_word_q     <= TX_WORD_RST;
			tx_header_q   <= 1'b0;
			sync_ticks_q  <= SYNC_TICKS_RST;
			error_limit_q <= ERROR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TX_WORD:     tx_word_q     <= cfg_data;
				REG_TX_HEADER:   tx_header_q   <= cfg_data[0];
				REG_SYNC_TICKS:  sync_ticks_q  <= cfg_data[SYNC_W-1:0];
				REG_ERROR_LIMIT: error_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_ECHO;
			clk_lvl_q <= 1'b1;
			run_q     <= '0;
			pos_q     <= '0;
			hdr_q     <= '0;
			txpar_q   <= 1'b0;
			cnt_q     <= '0;
		end else if (accept) begin
			ph_q      <= ph_n;
			clk_lvl_q <= new_clk;
			run_q     <= run_n;
			pos_q     <= pos_n;
			hdr_q     <= hdr_n;
			txpar_q   <= txpar_n;
			cnt_q     <= cnt_n;
		end
	end

	// Output queue; it also steps a report through the lanes one request at a time.
	slsm_outq #(
		.LINE_COUNT (LINE_COUNT)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.desc     (desc),
		.words    (lane_words),
		.ready    (q_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Input back-pressure only ever comes from results waiting on the output.
	a_ready_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// A drive result is always the only result of its tick.
	a_drive_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_DRIVE) |-> m_tlast)
		else $error("drive result not marked last");

	// A report that is taken part-way continues with further reports.
	a_report_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser == KIND_REPORT && !m_tlast)
		|=> (m_tvalid && m_tuser == KIND_REPORT))
		else $error("line report group broken");

	// The error count never moves while the link is between frames in resync.
	a_count_zero_in_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ph_q == PH_ECHO) |=> (cnt_q == $past(cnt_q)))
		else $error("error count changed during resync");

endmodule

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slsm_pkg::*;

	localparam int LANES = 6;
	localparam int PAYLOAD_BITS = 32;
	localparam int STALL_LIMIT = 1000;
	localparam logic [LANES-1:0] ALL_LINES = 6'h3F;

	// Frame phases as the link walks through them. The first four belong to resync.
	typedef enum logic [2:0] {
		LINK_ECHO,
		LINK_ALIGN,
		LINK_LOW1,
		LINK_LOW2,
		LINK_HEADER,
		LINK_DATA,
		LINK_PARITY
	} link_phase_t;

	// One output request as the link should present it.
	typedef struct {
		logic              kind;
		logic              clock_out;
		logic              data_out;
		logic [IDX_W-1:0]  line_index;
		word_t             line_word;
		logic              line_header;
		logic              line_bad;
		logic              resyncing;
		logic [CNT_W-1:0]  error_count;
		logic              last;
	} link_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TX_WORD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	six_lane_serial_link_master #(
		.LINE_COUNT(LANES),
		.FRAME_BITS(PAYLOAD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns period: six high, six low.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Our own copy of the register file, mirrored as each write is taken.
	word_t             set_word = TX_WORD_RST;
	logic              set_header = 1'b0;
	logic [SYNC_W-1:0] set_sync = SYNC_TICKS_RST;
	logic [CNT_W-1:0]  set_limit = ERROR_LIMIT_RST;

	// Our own copy of the link state, in its reset condition. The clock level is that
	// of the tick whose sample arrives next, which is high straight after reset.
	link_phase_t       link_phase = LINK_ECHO;
	logic              link_clk = 1'b1;
	int unsigned       echo_run = 0;
	int unsigned       bit_pos = 0;
	int unsigned       bad_total = 0;
	word_t             rx_word [LANES] = '{default: '0};
	logic [LANES-1:0]  rx_header = '0;
	logic [LANES-1:0]  rx_parity = '0;
	logic              tx_parity = 1'b0;
	int unsigned       reports_seen = 0;

	link_beat_t        pending_beats [$];
	int                mismatches = 0;

	// Idling controls shared between the stimulus and the receiver.
	bit                tx_gaps_on = 1'b1;
	bit                rx_gaps_on = 1'b1;
	int                rx_hold_len = 0;
	int                rx_stall = 0;
	int unsigned       quiet_cycles = 0;

	// Most gaps are nil or short; now and then a long one, so that pauses fall on
	// every phase of the frame.
	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_TX_WORD: set_word = value;
			REG_TX_HEADER: set_header = value[0];
			REG_SYNC_TICKS: set_sync = value[SYNC_W-1:0];
			REG_ERROR_LIMIT: set_limit = value[CNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Advances our copy of the link by one tick and queues the requests the block
	// should answer with.
	function automatic void advance_link(logic [LANES-1:0] lines);
		logic             clk_now;
		logic             drive;
		logic [LANES-1:0] bad;
		int unsigned      n_bad;
		bit               report;
		link_beat_t       b;

		clk_now = link_clk;
		bad = '0;
		report = 1'b0;
		case (link_phase)
			LINK_ECHO: begin
				if (lines == (clk_now ? ALL_LINES : '0)) begin
					if (echo_run < 7)
						echo_run++;
					// A setting of zero behaves as one, which this test gives for free.
					if (echo_run >= set_sync) begin
						echo_run = 0;
						link_phase = clk_now ? LINK_LOW1 : LINK_ALIGN;
					end
				end else begin
					echo_run = 0;
				end
			end
			LINK_ALIGN: link_phase = LINK_LOW1;
			LINK_LOW1: link_phase = (lines != '0) ? LINK_ECHO : LINK_LOW2;
			LINK_LOW2: link_phase = (lines != '0) ? LINK_ECHO : LINK_HEADER;
			LINK_HEADER: begin
				rx_header = lines;
				rx_word = '{default: '0};
				rx_parity = '0;
				bit_pos = 0;
				link_phase = LINK_DATA;
			end
			LINK_DATA: begin
				for (int i = 0; i < LANES; i++)
					rx_word[i][bit_pos] = lines[i];
				rx_parity ^= lines;
				if (bit_pos >= PAYLOAD_BITS - 1) begin
					bit_pos = 0;
					link_phase = LINK_PARITY;
				end else begin
					bit_pos++;
				end
			end
			default: begin
				bad = lines ^ rx_parity;
				n_bad = $countones(bad);
				if (n_bad == 0)
					bad_total = 0;
				else if (bad_total + n_bad > CNT_SAT)
					bad_total = CNT_SAT;
				else
					bad_total += n_bad;
				// Past the limit the link drops back into resync and forgets the count.
				if (bad_total > set_limit) begin
					bad_total = 0;
					echo_run = 0;
					link_phase = LINK_ECHO;
				end else begin
					link_phase = LINK_HEADER;
				end
				report = 1'b1;
				reports_seen++;
			end
		endcase

		link_clk = ~clk_now;
		case (link_phase)
			LINK_LOW1, LINK_LOW2: drive = 1'b0;
			LINK_HEADER: drive = set_header;
			LINK_DATA: begin
				drive = set_word[bit_pos];
				tx_parity ^= drive;
			end
			LINK_PARITY: begin
				drive = tx_parity;
				tx_parity = 1'b0;
			end
			default: drive = 1'b1;
		endcase

		b.clock_out = link_clk;
		b.data_out = drive;
		b.resyncing = (link_phase <= LINK_LOW2);
		b.error_count = bad_total[CNT_W-1:0];
		if (!report) begin
			b.kind = KIND_DRIVE;
			b.line_index = '0;
			b.line_word = '0;
			b.line_header = 1'b0;
			b.line_bad = 1'b0;
			b.last = 1'b1;
			pending_beats.push_back(b);
		end else begin
			for (int i = 0; i < LANES; i++) begin
				b.kind = KIND_REPORT;
				b.line_index = IDX_W'(i);
				b.line_word = rx_word[i];
				b.line_header = rx_header[i];
				b.line_bad = bad[i];
				b.last = (i == LANES - 1);
				pending_beats.push_back(b);
			end
		end
	endfunction

	// Line levels that a well-behaved set of slaves would return in the current
	// phase, with a chance of plain noise and, on the parity tick, of bad lanes.
	function automatic logic [LANES-1:0] make_lines(int noise_pct, int bad_pct);
		logic [LANES-1:0] lines;
		case (link_phase)
			LINK_ECHO: lines = link_clk ? ALL_LINES : '0;
			LINK_LOW1, LINK_LOW2: lines = '0;
			LINK_PARITY: begin
				lines = rx_parity;
				for (int i = 0; i < LANES; i++)
					if ($urandom_range(0, 99) < bad_pct)
						lines[i] = ~lines[i];
			end
			default: lines = LANES'($urandom_range(0, 63));
		endcase
		if (link_phase != LINK_PARITY && $urandom_range(0, 99) < noise_pct)
			lines = LANES'($urandom_range(0, 63));
		return lines;
	endfunction

	// Offers one tick and waits for the request to be taken. Within this task tvalid
	// is lowered only ahead of a gap, so it never falls and rises within one time step.
	task automatic send_tick(logic [LANES-1:0] lines);
		int gap;
		gap = pick_gap(tx_gaps_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - LANES){1'b0}}, lines};
		do @(posedge clk); while (!s_tready);
		advance_link(lines);
	endtask

	// The sender stops and waits until every expected request has come out.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
	endtask

	// Writes the four registers on consecutive cycles; enable only drops at the end.
	task automatic write_regs(word_t word, logic header, logic [SYNC_W-1:0] sync,
			logic [CNT_W-1:0] limit);
		logic [CFG_IDX_W-1:0]  regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		regs = '{REG_TX_WORD, REG_TX_HEADER, REG_SYNC_TICKS, REG_ERROR_LIMIT};
		vals = '{word, CFG_DATA_W'(header), CFG_DATA_W'(sync), CFG_DATA_W'(limit)};
		for (int r = 0; r < 4; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[r];
			cfg_data <= vals[r];
			@(posedge clk);
			apply_reg(regs[r], vals[r]);
		end
		cfg_we <= 1'b0;
	endtask

	// Sends ticks until the requested further frames report, or tries run out.
	task automatic run_frames(int frames, int noise_pct, int bad_pct);
		int unsigned target;
		int          tries;
		target = reports_seen + frames;
		tries = 0;
		while (reports_seen < target && tries < frames * 400) begin
			send_tick(make_lines(noise_pct, bad_pct));
			tries++;
		end
	endtask

	// Echo mismatches, a partial echo, a wake-up on each low tick and the all-low and
	// all-high extremes of the lines, under the reset settings.
	task automatic test_echo_and_low_ticks();
		// The first tick is driven high, so an all-low sample breaks the echo.
		send_tick('0);
		send_tick(make_lines(0, 0));
		send_tick(make_lines(0, 0));
		// One line out of step: the run starts again.
		send_tick(link_clk ? 6'h3E : 6'h01);
		while (link_phase == LINK_ECHO)
			send_tick(make_lines(0, 0));
		while (link_phase != LINK_LOW1)
			send_tick(make_lines(0, 0));
		// A line that is high during the first low tick sends the link back to echo.
		send_tick(6'h20);
		while (link_phase != LINK_LOW2)
			send_tick(make_lines(0, 0));
		// Likewise on the second low tick, this time with every line high.
		send_tick(ALL_LINES);
		while (link_phase != LINK_HEADER)
			send_tick(make_lines(0, 0));
	endtask

	// Finishes the frame with chosen data and one bad lane, which stays under the
	// reset limit.
	task automatic test_frame_parity();
		send_tick(ALL_LINES);
		send_tick('0);
		send_tick(ALL_LINES);
		send_tick(6'h2A);
		send_tick(6'h15);
		while (link_phase != LINK_PARITY)
			send_tick(make_lines(0, 0));
		send_tick(rx_parity ^ 6'h04);
	endtask

	// A new word and header land part way through a payload; the parity sent must
	// cover the bits that were really driven. A limit of zero then turns the bad
	// lanes of that frame into a resync, and the count reads back as zero.
	task automatic test_mid_frame_write();
		while (!(link_phase == LINK_DATA && bit_pos == 12))
			send_tick(make_lines(0, 0));
		wait_idle();
		write_regs(~set_word, ~set_header, 3'd1, 8'd0);
		run_frames(1, 0, 100);
	endtask

	// Extreme settings: a sync setting of zero, which acts as one, the largest
	// limit and an all-zero word, walked through resync into the next frame.
	task automatic test_register_settings();
		wait_idle();
		write_regs('0, 1'b0, 3'd0, CNT_SAT);
		repeat (6) send_tick(make_lines(0, 0));
	endtask

	// The receiver holds off for a long stretch while ticks keep coming, so the
	// output queue fills and the block refuses further requests; then the sender
	// pauses until every result is out.
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_hold_len = 80;
		repeat (8) send_tick(make_lines(0, 20));
		wait_idle();
		tx_gaps_on = 1'b1;
	endtask

	// Random settings, then mostly well-formed traffic with noise, and a stretch without gaps.
	task automatic test_random_ticks();
		wait_idle();
		write_regs($urandom, 1'($urandom_range(0, 1)), SYNC_W'($urandom_range(1, 3)),
			CNT_W'($urandom_range(2, 12)));
		for (int k = 0; k < 8; k++) begin
			tx_gaps_on = !(k >= 2 && k < 6);
			rx_gaps_on = tx_gaps_on;
			send_tick(make_lines(15, 20));
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Receiver: random gaps, plus a long hold-off counted here when one is asked for.
	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			rx_stall = rx_hold_len;
			rx_hold_len = 0;
		end else if (rx_stall == 0 && $urandom_range(0, 3) == 0) begin
			rx_stall = pick_gap(rx_gaps_on);
		end
		m_tready <= (rx_stall == 0);
		if (rx_stall > 0)
			rx_stall--;
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Every request taken on the master side is held against the oldest expectation.
	always @(posedge clk) begin
		link_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$error("result request arrived with nothing expected");
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("clock_out", want.clock_out, m_tdata[0]);
				check_field("data_out", want.data_out, m_tdata[1]);
				check_field("line_index", want.line_index, m_tdata[4:2]);
				check_field("line_word", want.line_word, m_tdata[36:5]);
				check_field("line_header", want.line_header, m_tdata[37]);
				check_field("line_bad", want.line_bad, m_tdata[38]);
				check_field("resyncing", want.resyncing, m_tdata[39]);
				check_field("error_count", want.error_count, m_tdata[47:40]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Watchdog: the run is declared hung once nothing has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_echo_and_low_ticks();
		test_frame_parity();
		test_mid_frame_write();
		test_register_settings();
		test_backpressure();
		test_random_ticks();
		wait_idle();
		// Waits on so that any stray request has time to show itself.
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/slsm_pkg.sv
hw/rtl/slsm_lane.sv
hw/rtl/slsm_merge.sv
hw/rtl/slsm_outq.sv
hw/rtl/six_lane_serial_link_master.sv
bench/testbench.sv
